@@ rtl/bfa_pkg.sv @@
// ----------------------------------------------------------------------------
// Best-fit allocator package
// Shared constants, command codes and the command record passed from the
// front part to the back part through the command queue.
// ----------------------------------------------------------------------------
package bfa_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned MAX_BLOCKS_DEF = 16;
  localparam int unsigned SIZE_BITS_DEF  = 16;

  // Fixed field widths on the stream ports.
  localparam int unsigned IN_IDX_W   = 4;
  localparam int unsigned IN_SIZE_W  = 16;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 24;

  // Configuration port.
  localparam int unsigned CNT_REG_W  = 5;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  // Depth of the queue between the front and the back part.
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic {
    REG_BLOCK_COUNT = 1'b0
  } reg_idx_e;

  typedef enum logic {
    CMD_LOAD    = 1'b0,
    CMD_REQUEST = 1'b1
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e             kind;
    logic [IN_IDX_W-1:0]   idx;
    logic [IN_SIZE_W-1:0]  value;
  } cmd_t;

endpackage

@@ rtl/bfa_fifo.sv @@
// ----------------------------------------------------------------------------
// Best-fit allocator command queue
// Small first-in first-out buffer of commands that decouples the front part
// from the scanning back part.
// ----------------------------------------------------------------------------
module bfa_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bfa_pkg::cmd_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output bfa_pkg::cmd_t pop_data_o
);
  import bfa_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  cmd_t            slot_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o     = (count_q == CntW'(QUEUE_DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = slot_q[rd_ptr_q];
  assign do_push    = push_i & ~full_o;
  assign do_pop     = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ rtl/bfa_front.sv @@
// ----------------------------------------------------------------------------
// Best-fit allocator front part
// Takes input beats, sorts them into loads and requests, drops loads aimed
// beyond the table and pushes the rest into the command queue.
// ----------------------------------------------------------------------------
module bfa_front #(
  parameter int unsigned MAX_BLOCKS = bfa_pkg::MAX_BLOCKS_DEF
) (
  input  logic                             s_valid_i,
  output logic                             s_ready_o,
  // Fields from bit 0 up: block_index, block_size, request_size, zero pad.
  input  logic [bfa_pkg::IN_DATA_W-1:0]    s_data_i,
  // Field: action.
  input  logic                             s_user_i,
  input  logic                             q_full_i,
  output logic                             q_push_o,
  output bfa_pkg::cmd_t                    q_cmd_o
);
  import bfa_pkg::*;

  logic                 accept;
  logic                 is_request;
  logic                 in_table;
  logic [IN_IDX_W-1:0]  blk_idx;
  logic [IN_SIZE_W-1:0] blk_size;
  logic [IN_SIZE_W-1:0] req_size;

  assign blk_idx    = s_data_i[IN_IDX_W-1:0];
  assign blk_size   = s_data_i[IN_IDX_W +: IN_SIZE_W];
  assign req_size   = s_data_i[IN_IDX_W+IN_SIZE_W +: IN_SIZE_W];
  assign is_request = (cmd_kind_e'(s_user_i) == CMD_REQUEST);
  assign in_table   = (32'(blk_idx) < MAX_BLOCKS);

  assign s_ready_o = ~q_full_i;
  assign accept    = s_valid_i & s_ready_o;

  // A load outside the table is taken from the stream and then forgotten.
  assign q_push_o      = accept & (is_request | in_table);
  assign q_cmd_o.kind  = is_request ? CMD_REQUEST : CMD_LOAD;
  assign q_cmd_o.idx   = blk_idx;
  assign q_cmd_o.value = is_request ? req_size : blk_size;

endmodule

@@ rtl/bfa_back.sv @@
// ----------------------------------------------------------------------------
// Best-fit allocator back part
// Holds the size table, writes loads and scans the table one entry per cycle
// for the best-fitting block, zeroes its size if found and presents the result beat.
// ----------------------------------------------------------------------------
module bfa_back #(
  parameter int unsigned MAX_BLOCKS = bfa_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned SIZE_BITS  = bfa_pkg::SIZE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              q_valid_i,
  input  bfa_pkg::cmd_t                     q_cmd_i,
  output logic                              q_pop_o,
  input  logic [bfa_pkg::CNT_REG_W-1:0]     block_count_i,
  output logic                              m_valid_o,
  input  logic                              m_ready_i,
  // Fields from bit 0 up: chosen_block, leftover, zero pad.
  output logic [bfa_pkg::OUT_DATA_W-1:0]    m_data_o,
  // Field: found.
  output logic                              m_user_o
);
  import bfa_pkg::*;

  localparam int unsigned IdxW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CntW = $clog2(MAX_BLOCKS + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } bk_state_e;

  bk_state_e state_q, state_d;

  // Size table with one valid bit per entry; an entry never written reads zero.
  logic [SIZE_BITS-1:0]  mem_q [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] valid_q;
  logic [SIZE_BITS-1:0]  rd_data_q;
  logic                  rd_valid_q;
  logic                  wr_en;
  logic [IdxW-1:0]       wr_addr;
  logic [SIZE_BITS-1:0]  wr_data;
  logic [IdxW-1:0]       rd_addr;

  logic [CntW-1:0]       limit;
  logic [CntW-1:0]       ptr_q, ptr_d;
  logic                  pend_q, pend_d;
  logic [IdxW-1:0]       cmp_idx_q, cmp_idx_d;
  logic [SIZE_BITS-1:0]  req_q, req_d;
  logic                  have_q, have_d;
  logic [IdxW-1:0]       best_idx_q, best_idx_d;
  logic [SIZE_BITS-1:0]  best_size_q, best_size_d;
  logic [SIZE_BITS-1:0]  entry;
  logic                  finish;

  logic                  out_valid_q, out_valid_d;
  logic                  out_found_q, out_found_d;
  logic [IN_IDX_W-1:0]   out_block_q, out_block_d;
  logic [IN_SIZE_W-1:0]  out_left_q, out_left_d;

  assign limit   = (32'(block_count_i) > MAX_BLOCKS) ? CntW'(MAX_BLOCKS)
                                                     : CntW'(block_count_i);
  assign rd_addr = ptr_q[IdxW-1:0];
  assign entry   = rd_valid_q ? rd_data_q : '0;
  assign finish  = (state_q == ST_SCAN) && (ptr_q == limit) && !pend_q;

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    pend_d      = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    req_d       = req_q;
    have_d      = have_q;
    best_idx_d  = best_idx_q;
    best_size_d = best_size_q;
    q_pop_o     = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = IdxW'(q_cmd_i.idx);
    wr_data     = SIZE_BITS'(q_cmd_i.value);
    out_valid_d = out_valid_q & ~m_ready_i;
    out_found_d = out_found_q;
    out_block_d = out_block_q;
    out_left_d  = out_left_q;

    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          if (q_cmd_i.kind == CMD_LOAD) begin
            q_pop_o = 1'b1;
            wr_en   = 1'b1;
          end else if (!out_valid_q) begin
            // A request waits until the result register is free.
            q_pop_o = 1'b1;
            req_d   = SIZE_BITS'(q_cmd_i.value);
            have_d  = 1'b0;
            ptr_d   = '0;
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (ptr_q != limit) begin
          pend_d    = 1'b1;
          cmp_idx_d = ptr_q[IdxW-1:0];
          ptr_d     = ptr_q + 1'b1;
        end
        // Strictly smaller replaces the best, so equal sizes keep the lower index.
        if (pend_q && (entry >= req_q) && (!have_q || (best_size_q > entry))) begin
          have_d      = 1'b1;
          best_idx_d  = cmp_idx_q;
          best_size_d = entry;
        end
        if (finish) begin
          out_valid_d = 1'b1;
          out_found_d = have_q;
          out_block_d = have_q ? IN_IDX_W'(best_idx_q) : '0;
          out_left_d  = have_q ? IN_SIZE_W'(best_size_q - req_q) : '0;
          wr_en       = have_q;
          wr_addr     = best_idx_q;
          wr_data     = '0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      rd_valid_q  <= 1'b0;
      pend_q      <= 1'b0;
      have_q      <= 1'b0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_valid_q  <= valid_q[rd_addr];
      pend_q      <= pend_d;
      have_q      <= have_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
      if (wr_en) begin
        valid_q[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_data_q   <= mem_q[rd_addr];
    cmp_idx_q   <= cmp_idx_d;
    req_q       <= req_d;
    best_idx_q  <= best_idx_d;
    best_size_q <= best_size_d;
    out_found_q <= out_found_d;
    out_block_q <= out_block_d;
    out_left_q  <= out_left_d;
  end

  assign m_valid_o = out_valid_q;
  assign m_user_o  = out_found_q;
  assign m_data_o  = {{(OUT_DATA_W - IN_IDX_W - IN_SIZE_W){1'b0}}, out_left_q, out_block_q};

  a_ptr_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (ptr_q <= limit))
    else $error("scan pointer ran past the block count");

  a_req_needs_free_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop_o && (q_cmd_i.kind == CMD_REQUEST)) |-> !out_valid_q)
    else $error("request started while a result still waits");

  a_best_fits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SCAN) && have_q) |-> (best_size_q >= req_q))
    else $error("chosen block is smaller than the request");

  a_idle_no_compare : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pend_q)
    else $error("compare pending outside a scan");

endmodule

@@ rtl/best_fit_block_allocator.sv @@
// ----------------------------------------------------------------------------
// Best-fit block allocator
// Input beats are taken one per cycle while the four-entry command queue has room.
// A load is written into the table when the idle back part pops it from the queue.
// A request makes the back part scan the first min(block_count, MAX_BLOCKS)
// entries of the table memory one entry per cycle; the result beat is presented
// when that scan ends.
// Reset clears every table valid bit at once, so all sizes read zero.
// ----------------------------------------------------------------------------
module best_fit_block_allocator #(
  parameter int unsigned MAX_BLOCKS = bfa_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned SIZE_BITS  = bfa_pkg::SIZE_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // Fields from bit 0 up: block_index, block_size, request_size, zero pad.
  input  logic [bfa_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // Field: action.
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // Fields from bit 0 up: chosen_block, leftover, zero pad.
  output logic [bfa_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // Field: found.
  output logic                             m_axis_tuser,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bfa_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [bfa_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [bfa_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);
  import bfa_pkg::*;

  logic [CNT_REG_W-1:0] block_count_q;
  logic                 cfg_write;
  reg_idx_e             reg_sel;
  logic                 q_full;
  logic                 q_push;
  logic                 q_pop;
  logic                 q_valid;
  cmd_t                 push_cmd;
  cmd_t                 head_cmd;

  // Registers sit on 32-bit words, so the word index starts at bit 2.
  assign reg_sel   = reg_idx_e'(paddr[2]);
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_count_q <= '0;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_BLOCK_COUNT: block_count_q <= pwdata[CNT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_BLOCK_COUNT: prdata = APB_DATA_W'(block_count_q);
      default:         prdata = '0;
    endcase
  end

  bfa_front #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_front (
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_data_i  (s_axis_tdata),
    .s_user_i  (s_axis_tuser),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_cmd_o   (push_cmd)
  );

  bfa_fifo u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (push_cmd),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (head_cmd)
  );

  bfa_back #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_cmd_i       (head_cmd),
    .q_pop_o       (q_pop),
    .block_count_i (block_count_q),
    .m_valid_o     (m_axis_tvalid),
    .m_ready_i     (m_axis_tready),
    .m_data_o      (m_axis_tdata),
    .m_user_o      (m_axis_tuser)
  );

endmodule
